### rtl/sfr_pkg.sv
// Shared types and constants for the stuffed frame receiver.
package sfr_pkg;

    // Line protocol bytes.
    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] ESC_BYTE    = 8'h7D;
    localparam logic [7:0] ESC_MASK    = 8'h20;
    localparam logic [7:0] ADDR_RESET  = 8'h03;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Frame status codes.
    localparam logic [1:0] ST_COMMAND   = 2'd0;
    localparam logic [1:0] ST_DATA_GOOD = 2'd1;
    localparam logic [1:0] ST_DATA_BAD  = 2'd2;

    // Configuration register index.
    localparam logic REG_ADDRESS = 1'b0;

    // Packed output item width, rounded up to whole bytes.
    localparam int RES_BITS  = 8 + 2 + 8 + 1 + 16;
    localparam int DATA_BITS = ((RES_BITS + 7) / 8) * 8;

    // One result item from the decoder.
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  frame_status;
        logic [7:0]  control_value;
        logic        sequence_bit;
        logic [15:0] payload_length;
    } t_result;

endpackage

### rtl/sfr_regs.sv
// APB configuration register block holding the expected address byte.
module sfr_regs
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_address_byte
);

    logic [7:0] r_address_byte;
    logic       w_write;

    // A write completes in the access phase; pready is always high.
    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready;

    // Address register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_byte <= ADDR_RESET;
        end else if (w_write && (paddr[2] == REG_ADDRESS)) begin
            r_address_byte <= pwdata[7:0];
        end
    end

    // Read back; addresses beyond the register read as zero.
    assign prdata = (paddr[2] == REG_ADDRESS) ? {24'd0, r_address_byte} : 32'd0;

    assign o_address_byte = r_address_byte;

endmodule

### rtl/sfr_decode.sv
// Frame state machine: flag hunt, header check, destuffing and block check.
module sfr_decode
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_line_byte,
    input  logic [7:0] i_address_byte,
    output t_result    o_result
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_FLAG = 3'd1;
    localparam logic [2:0] PH_ADDR = 3'd2;
    localparam logic [2:0] PH_CTRL = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;

    logic [2:0]  r_phase,        n_phase;
    logic [7:0]  r_held_control, n_held_control;
    logic [7:0]  r_running_xor,  n_running_xor;
    logic [7:0]  r_held_byte,    n_held_byte;
    logic        r_held_valid,   n_held_valid;
    logic        r_escape_seen,  n_escape_seen;
    logic [15:0] r_byte_count,   n_byte_count;
    logic [7:0]  w_value;
    logic        w_good;
    t_result     w_result;

    // Next state and result for the byte on the input.
    always_comb begin
        n_phase        = r_phase;
        n_held_control = r_held_control;
        n_running_xor  = r_running_xor;
        n_held_byte    = r_held_byte;
        n_held_valid   = r_held_valid;
        n_escape_seen  = r_escape_seen;
        n_byte_count   = r_byte_count;
        w_result       = '0;
        w_value        = r_escape_seen ? (i_line_byte ^ ESC_MASK) : i_line_byte;
        w_good         = r_held_valid && !r_escape_seen && (r_running_xor == r_held_byte);

        if (r_phase != PH_FLAG && r_phase != PH_ADDR && r_phase != PH_CTRL &&
            r_phase != PH_BODY) begin
            // Hunting: only a flag matters.
            n_escape_seen = 1'b0;
            n_phase       = (i_line_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
        end else if (i_line_byte == FLAG_BYTE) begin
            n_escape_seen = 1'b0;
            if (r_phase == PH_BODY) begin
                // Closing flag: report the frame and go back to hunting.
                w_result.valid         = 1'b1;
                w_result.kind          = KIND_REPORT;
                w_result.control_value = r_held_control;
                if (!r_held_valid && !r_escape_seen) begin
                    w_result.frame_status = ST_COMMAND;
                    w_result.sequence_bit = r_held_control[7];
                end else begin
                    w_result.frame_status   = w_good ? ST_DATA_GOOD : ST_DATA_BAD;
                    w_result.sequence_bit   = r_held_control[6];
                    w_result.payload_length = r_byte_count;
                end
                n_phase = PH_HUNT;
            end else begin
                // A raw flag inside the header restarts it.
                n_phase = PH_FLAG;
            end
        end else if (i_line_byte == ESC_BYTE && !r_escape_seen) begin
            n_escape_seen = 1'b1;
        end else begin
            n_escape_seen = 1'b0;
            case (r_phase)
                PH_FLAG: begin
                    n_phase = (w_value == i_address_byte) ? PH_ADDR : PH_HUNT;
                end
                PH_ADDR: begin
                    n_held_control = w_value;
                    n_phase        = PH_CTRL;
                end
                PH_CTRL: begin
                    if (w_value == (i_address_byte ^ r_held_control)) begin
                        n_running_xor = 8'd0;
                        n_held_byte   = 8'd0;
                        n_held_valid  = 1'b0;
                        n_byte_count  = 16'd0;
                        n_phase       = PH_BODY;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    // Body: release the held byte, keep the new one back.
                    if (r_held_valid) begin
                        n_running_xor = r_running_xor ^ r_held_byte;
                        if (r_byte_count != 16'hFFFF) begin
                            n_byte_count = r_byte_count + 16'd1;
                        end
                        w_result.valid        = 1'b1;
                        w_result.kind         = KIND_PAYLOAD;
                        w_result.payload_byte = r_held_byte;
                    end
                    n_held_byte  = w_value;
                    n_held_valid = 1'b1;
                end
            endcase
        end
    end

    // State registers advance only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_held_control <= 8'd0;
            r_running_xor  <= 8'd0;
            r_held_byte    <= 8'd0;
            r_held_valid   <= 1'b0;
            r_escape_seen  <= 1'b0;
            r_byte_count   <= 16'd0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_held_control <= n_held_control;
            r_running_xor  <= n_running_xor;
            r_held_byte    <= n_held_byte;
            r_held_valid   <= n_held_valid;
            r_escape_seen  <= n_escape_seen;
            r_byte_count   <= n_byte_count;
        end
    end

    assign o_result = w_result;

    // A report always leaves the block hunting.
    a_report_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_result.valid && w_result.kind == KIND_REPORT) |=> (r_phase == PH_HUNT))
        else $error("report did not return to hunting");

    // Payload bytes only come out of the body phase with a held byte.
    a_payload_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_result.valid && w_result.kind == KIND_PAYLOAD) |-> (r_phase == PH_BODY && r_held_valid))
        else $error("payload item outside the body");

    // An accepted payload item advances or holds the saturated count.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_result.valid && w_result.kind == KIND_PAYLOAD) |=>
        (r_byte_count == $past(r_byte_count) + 16'd1 || r_byte_count == 16'hFFFF))
        else $error("byte count did not advance");

endmodule

### rtl/stuffed_frame_receiver_core.sv
// Top level of the stuffed frame receiver: decoder, registers and output skid buffer.
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata[7:0] line_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready    tuser kind, tdata report and payload fields
//  apb       in   psel/penable/pwrite/pready     paddr[2:0], pwdata, prdata
//
// One line byte is taken per cycle while s_axis_tready is high; its result, if any, is
// registered into the output register, or into the skid entry when the output register is held.
// The decoder is a single combinational pass between the state and output registers.
// A two-entry output stage (output register plus skid) absorbs one item of downstream
// stall without blocking input; s_axis_tready drops only while the skid entry is full.
// Reset is synchronous and active low and clears all control state and the address
// register to 0x03; no clearing pass is needed.
module stuffed_frame_receiver_core
    import sfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: line_byte[7:0].
    input  logic [7:0]           s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: payload_byte[7:0], frame_status[9:8], control_value[17:10],
    // sequence_bit[18], payload_length[34:19], zero fill above.
    output logic [DATA_BITS-1:0] m_axis_tdata,
    // Fields from bit 0: result_kind.
    output logic                 m_axis_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [7:0]           w_address_byte;
    logic                 w_accept;
    t_result              w_result;
    logic [DATA_BITS:0]   w_packed;
    logic                 w_push;
    logic                 w_pop;
    logic                 r_out_valid;
    logic [DATA_BITS:0]   r_out_data;
    logic                 r_skid_valid;
    logic [DATA_BITS:0]   r_skid_data;

    sfr_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_address_byte (w_address_byte)
    );

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    sfr_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_line_byte    (s_axis_tdata),
        .i_address_byte (w_address_byte),
        .o_result       (w_result)
    );

    // Pack the result: kind on top, data fields from bit 0.
    assign w_packed = {w_result.kind,
                       {(DATA_BITS - RES_BITS){1'b0}},
                       w_result.payload_length,
                       w_result.sequence_bit,
                       w_result.control_value,
                       w_result.frame_status,
                       w_result.payload_byte};

    assign w_push = w_accept && w_result.valid;
    assign w_pop  = r_out_valid && m_axis_tready;

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_pop || !r_out_valid) begin
            r_out_valid <= w_push;
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_pop || !r_out_valid) begin
            if (w_push) begin
                r_out_data <= w_packed;
            end
        end else if (w_push) begin
            r_skid_data <= w_packed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data[DATA_BITS-1:0];
    assign m_axis_tuser  = r_out_data[DATA_BITS];

    // The skid entry is only ever filled behind a full output register.
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full with empty output register");

    // A skid entry waits until the output register drains.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !m_axis_tready) |=> (r_skid_valid && $stable(r_skid_data)))
        else $error("skid entry lost during stall");

endmodule
